// ===== design/sli_pkg.sv =====
// Package for the sorted list block: sizes, operation and status codes,
// cell command and status types. No dependencies.
package sli_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int VAL_W      = 32;
  localparam int FLD_W      = 5;   // width of position, removed and held
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  // Operation codes on the input channel
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_FULL     = 3'd1;
  localparam logic [2:0] STAT_DELETED  = 3'd2;
  localparam logic [2:0] STAT_ENTRY    = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  // Cell commands
  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;
  localparam logic [1:0] CELL_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] opnd;
    logic [CNT_W-1:0] cnt;
  } cell_cmd_t;

  typedef struct packed {
    logic gt;      // valid and greater than the operand
    logic place;   // insert lands here
    logic chain;   // a match sits at or left of this cell
  } cell_stat_t;

endpackage

// ===== design/sli_cell.sv =====
// One cell of the sorted list chain: holds one entry and swaps data with
// its neighbors on insert, delete and rotate. Depends on sli_pkg.
module sli_cell (
  input  logic                          clk,
  input  sli_pkg::cell_cmd_t            cmd,
  input  logic [sli_pkg::IDX_W-1:0]     idx,
  input  logic [sli_pkg::VAL_W-1:0]     left_val,
  input  logic                          left_gt,
  input  logic                          chain_in,
  input  logic [sli_pkg::VAL_W-1:0]     right_val,
  input  logic [sli_pkg::VAL_W-1:0]     head_val,
  output logic [sli_pkg::VAL_W-1:0]     val_o,
  output sli_pkg::cell_stat_t           stat_o
);
  import sli_pkg::*;

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             valid;
  logic             match;
  logic             at_end;
  logic             is_tail;

  always_comb begin
    valid   = CNT_W'(idx) < cmd.cnt;
    at_end  = CNT_W'(idx) == cmd.cnt;
    is_tail = (CNT_W'(idx) + CNT_W'(1)) == cmd.cnt;
    match   = valid && (val_r == cmd.opnd);
    stat_o.gt    = valid && ($signed(val_r) > $signed(cmd.opnd));
    stat_o.chain = chain_in | match;
    stat_o.place = (stat_o.gt || at_end) && !left_gt;
  end

  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      CELL_INS: begin
        // open a gap: greater entries move one cell right
        if (left_gt) begin
          val_nxt = left_val;
        end else if (stat_o.place) begin
          val_nxt = cmd.opnd;
        end
      end
      CELL_DEL: begin
        // drop the first match, pull the rest left
        if (stat_o.chain) begin
          val_nxt = right_val;
        end
      end
      CELL_ROT: begin
        val_nxt = is_tail ? head_val : right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;

endmodule

// ===== design/sorted_list_insert_delete.sv =====
// Sorted list block top level: control, output register and the cell chain.
// Depends on sli_pkg and sli_cell.
//
// Keeps up to LIST_DEPTH signed 32-bit values in ascending order.
// Input channel in_*: tdata carries operation and value. Operation insert
// places the value before the first strictly larger entry; delete removes
// every equal entry; list emits every entry in order.
// Result channel out_*: tdata carries status, item value, position, removed
// and held count; tlast marks the final result of a transaction.
// Timing: an insert result is registered and shows in the cycle after the
// input is accepted. Delete removes the matches, then loads its result; list
// loads one result per entry (a single empty result for an empty list). The cell
// chain is busy for the whole operation, so in_tready stays low until the last
// result is loaded. Operation code 3 is taken and dropped with no result. Rate is
// set by the chain: one entry is removed, or shifted out unless stalled, per cycle.
// Reset (rst_n low, synchronous) empties the list and clears out_tvalid;
// stored values need no clearing since only occupied cells are read.
// A stalled receiver (out_tready low) holds the output register and freezes
// delete completion and list rotation until the result is taken.
module sorted_list_insert_delete (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [1:0] operation, [33:2] value, zero padding above
  input  logic [sli_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] status, [34:3] item_value, [39:35] position, [44:40] removed,
  // [49:45] held, zero padding above
  output logic [sli_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tlast
);
  import sli_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEL  = 2'd1;
  localparam logic [1:0] ST_LIST = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] lidx_r, lidx_nxt;
  logic [VAL_W-1:0] opnd_r, opnd_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [1:0]       in_op;
  logic [VAL_W-1:0] in_val;
  logic             in_fire;
  logic             can_load;
  logic             full;
  logic             any_match;
  logic             list_tail;
  logic [IDX_W-1:0] slot;

  cell_cmd_t        cmd;
  logic [VAL_W-1:0] cell_val [LIST_DEPTH];
  cell_stat_t       stat     [LIST_DEPTH];

  assign in_op     = in_tdata[1:0];
  assign in_val    = in_tdata[VAL_W+1:2];
  assign can_load  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && can_load;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = occ_r == CNT_W'(LIST_DEPTH);
  assign any_match = stat[LIST_DEPTH-1].chain;
  assign list_tail = (CNT_W'(lidx_r) + CNT_W'(1)) == occ_r;

  // encode the one-hot insert slot
  always_comb begin
    slot = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (stat[i].place) begin
        slot = slot | IDX_W'(i);
      end
    end
  end

  function automatic logic [OUT_TDATA_W-1:0] pack_out(
    input logic [2:0]       status,
    input logic [VAL_W-1:0] value,
    input logic [FLD_W-1:0] pos,
    input logic [FLD_W-1:0] rem,
    input logic [FLD_W-1:0] held
  );
    logic [OUT_TDATA_W-1:0] d;
    d = '0;
    d[2:0]   = status;
    d[34:3]  = value;
    d[39:35] = pos;
    d[44:40] = rem;
    d[49:45] = held;
    return d;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    rem_nxt       = rem_r;
    lidx_nxt      = lidx_r;
    opnd_nxt      = opnd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    cmd.op        = CELL_HOLD;
    cmd.opnd      = opnd_r;
    cmd.cnt       = occ_r;

    case (state_r)
      ST_IDLE: begin
        cmd.opnd = in_val;
        if (in_fire) begin
          case (in_op)
            OP_INSERT: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (full) begin
                out_data_nxt = pack_out(STAT_FULL, in_val, '0, '0, FLD_W'(occ_r));
              end else begin
                cmd.op       = CELL_INS;
                occ_nxt      = occ_r + CNT_W'(1);
                out_data_nxt = pack_out(STAT_INSERTED, in_val, FLD_W'(slot), '0,
                                        FLD_W'(occ_r + CNT_W'(1)));
              end
            end
            OP_DELETE: begin
              opnd_nxt  = in_val;
              rem_nxt   = '0;
              state_nxt = ST_DEL;
            end
            OP_LIST: begin
              if (occ_r == '0) begin
                out_valid_nxt = 1'b1;
                out_last_nxt  = 1'b1;
                out_data_nxt  = pack_out(STAT_EMPTY, in_val, '0, '0, '0);
              end else begin
                lidx_nxt  = '0;
                state_nxt = ST_LIST;
              end
            end
            default: begin
              // unused code: drop the transaction
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DEL: begin
        if (any_match) begin
          cmd.op  = CELL_DEL;
          occ_nxt = occ_r - CNT_W'(1);
          rem_nxt = rem_r + CNT_W'(1);
        end else if (can_load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_data_nxt  = pack_out(STAT_DELETED, opnd_r, '0, FLD_W'(rem_r),
                                   FLD_W'(occ_r));
          state_nxt     = ST_IDLE;
        end
      end
      ST_LIST: begin
        if (can_load) begin
          // emit the head, rotate the list one cell left
          cmd.op        = CELL_ROT;
          out_valid_nxt = 1'b1;
          out_last_nxt  = list_tail;
          out_data_nxt  = pack_out(STAT_ENTRY, cell_val[0], FLD_W'(lidx_r), '0,
                                   FLD_W'(occ_r));
          lidx_nxt      = lidx_r + IDX_W'(1);
          if (list_tail) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      rem_r       <= '0;
      lidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      rem_r       <= rem_nxt;
      lidx_r      <= lidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opnd_r     <= opnd_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
    logic [VAL_W-1:0] lval;
    logic             lgt;
    logic             lchain;
    logic [VAL_W-1:0] rval;

    if (g == 0) begin : g_head
      assign lval   = '0;
      assign lgt    = 1'b0;
      assign lchain = 1'b0;
    end else begin : g_body
      assign lval   = cell_val[g-1];
      assign lgt    = stat[g-1].gt;
      assign lchain = stat[g-1].chain;
    end

    if (g == LIST_DEPTH - 1) begin : g_tail
      assign rval = cell_val[g];
    end else begin : g_next
      assign rval = cell_val[g+1];
    end

    sli_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (IDX_W'(g)),
      .left_val  (lval),
      .left_gt   (lgt),
      .chain_in  (lchain),
      .right_val (rval),
      .head_val  (cell_val[0]),
      .val_o     (cell_val[g]),
      .stat_o    (stat[g])
    );
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(LIST_DEPTH))
    else $error("occupancy above list depth");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL) |=> (occ_r <= $past(occ_r)))
    else $error("delete grew the list");

  a_list_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LIST) |=> (occ_r == $past(occ_r)))
    else $error("list-out changed occupancy");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_op == OP_INSERT && !full) |=> (occ_r == $past(occ_r) + CNT_W'(1)))
    else $error("insert did not add one entry");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DEL && any_match) |=> (rem_r == $past(rem_r) + CNT_W'(1)))
    else $error("removed count out of step");

endmodule

// ===== test/tb_sorted_list_insert_delete.sv =====
// Self-checking testbench for sorted_list_insert_delete: streams insert, delete,
// list and unused-code transactions with random flow control and checks every result.
// Depends on sli_pkg and the sorted_list_insert_delete RTL.
module tb_sorted_list_insert_delete;
  import sli_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM = 500;

  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [VAL_W-1:0] item_value;
    logic [4:0]       position;
    logic [4:0]       removed;
    logic [4:0]       held;
    logic             last;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  list_cmd_t    cmd_q[$];
  list_result_t expected_q[$];
  list_cmd_t    next_cmd;
  list_result_t seen;
  list_result_t want;

  logic signed [VAL_W-1:0] shadow_list [LIST_DEPTH];
  int shadow_cnt = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_cycle = 0;
  int hold_left = 0;

  sorted_list_insert_delete dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void expect_result(logic [2:0] status, logic [VAL_W-1:0] v, int pos,
                                        int rem, int held, logic last);
    list_result_t r;
    r.status     = status;
    r.item_value = v;
    r.position   = pos[4:0];
    r.removed    = rem[4:0];
    r.held       = held[4:0];
    r.last       = last;
    expected_q.push_back(r);
  endfunction

  // Update the shadow list for one accepted transaction and queue its results.
  task automatic predict_list_op(input logic [1:0] op, input logic signed [VAL_W-1:0] v);
    int slot;
    int w;
    int old_cnt;
    case (op)
      OP_INSERT: begin
        if (shadow_cnt >= LIST_DEPTH) begin
          expect_result(STAT_FULL, v, 0, 0, shadow_cnt, 1'b1);
        end else begin
          slot = shadow_cnt;
          for (int i = 0; i < shadow_cnt; i++) begin
            if (shadow_list[i] > v) begin
              slot = i;
              break;
            end
          end
          for (int i = shadow_cnt; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = v;
          shadow_cnt++;
          expect_result(STAT_INSERTED, v, slot, 0, shadow_cnt, 1'b1);
        end
      end
      OP_DELETE: begin
        w = 0;
        old_cnt = shadow_cnt;
        for (int i = 0; i < old_cnt; i++) begin
          if (shadow_list[i] != v) begin
            shadow_list[w] = shadow_list[i];
            w++;
          end
        end
        shadow_cnt = w;
        expect_result(STAT_DELETED, v, 0, old_cnt - w, w, 1'b1);
      end
      OP_LIST: begin
        if (shadow_cnt == 0) begin
          expect_result(STAT_EMPTY, v, 0, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_cnt; i++)
            expect_result(STAT_ENTRY, shadow_list[i], i, 0, shadow_cnt, i == shadow_cnt - 1);
        end
      end
      default: ;
    endcase
  endtask

  function automatic void add_cmd(logic [1:0] op, logic [VAL_W-1:0] v);
    list_cmd_t c;
    c.op    = op;
    c.value = v;
    cmd_q.push_back(c);
  endfunction

  // Draw mostly from a small pool so duplicates and matching deletes are common.
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return 32'd7;
      5: return -32'sd5;
      6: return 32'd1000;
      7: return -32'sd1000;
      default: return $urandom();
    endcase
  endfunction

  task automatic flag_mismatch(input string why, input list_result_t e, input list_result_t g);
    errors++;
    if (errors <= 10)
      $display({"%0t %s: exp st=%0d val=%h pos=%0d rem=%0d held=%0d last=%0d",
                " | got st=%0d val=%h pos=%0d rem=%0d held=%0d last=%0d"},
               $time, why, e.status, e.item_value, e.position, e.removed, e.held, e.last,
               g.status, g.item_value, g.position, g.removed, g.held, g.last);
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_list_op(in_tdata[1:0], in_tdata[33:2]);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          in_tvalid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (cmd_q.size() > 0) begin
          next_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'b0, next_cmd.value, next_cmd.op};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: steps through four ready patterns in turn; a long hold-off now and then
  // lets the block back up and drop in_tready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycle   <= 0;
      hold_left  <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (rx_cycle % 2048 == 600) begin
        hold_left  <= 300;
        out_tready <= 1'b0;
      end else begin
        case ((rx_cycle >> 8) % 4)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= (rx_cycle % 4 == 0);
          default: out_tready <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen.status     = out_tdata[2:0];
      seen.item_value = out_tdata[34:3];
      seen.position   = out_tdata[39:35];
      seen.removed    = out_tdata[44:40];
      seen.held       = out_tdata[49:45];
      seen.last       = out_tlast;
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, seen);
      end else begin
        want = expected_q.pop_front();
        if (seen.status != want.status || seen.item_value != want.item_value ||
            seen.position != want.position || seen.removed != want.removed ||
            seen.held != want.held || seen.last != want.last)
          flag_mismatch("result mismatch", want, seen);
      end
    end
  end

  initial begin
    int counted;
    int seg_left;
    int ins_pct;
    int r;
    logic [1:0] op;

    // Directed part: empty list-out, extremes, duplicates, deletes, unused code,
    // fill to full, drop on full, full list-out.
    add_cmd(OP_LIST, 32'h1234_5678);
    add_cmd(OP_INSERT, 32'h7fff_ffff);
    add_cmd(OP_INSERT, 32'h8000_0000);
    add_cmd(OP_INSERT, 32'd0);
    add_cmd(OP_INSERT, 32'hffff_ffff);
    add_cmd(OP_INSERT, 32'd0);
    add_cmd(OP_LIST, 32'd0);
    add_cmd(OP_DELETE, 32'd0);
    add_cmd(OP_DELETE, 32'd12345);
    add_cmd(OP_UNUSED, 32'hdead_beef);
    for (int i = 0; i < 13; i++) add_cmd(OP_INSERT, (i % 3 == 0) ? 32'h7fff_ffff : $urandom());
    add_cmd(OP_INSERT, 32'h5555_aaaa);
    add_cmd(OP_LIST, 32'hffff_ffff);

    // Random part in segments that lean toward filling or draining the list.
    counted  = 0;
    seg_left = 0;
    ins_pct  = 60;
    while (counted < N_RANDOM) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: ins_pct = 85;
          1: ins_pct = 60;
          default: ins_pct = 35;
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_UNUSED;
      else if (r < 12) op = OP_LIST;
      else if (r < 12 + ins_pct * 88 / 100) op = OP_INSERT;
      else op = OP_DELETE;
      add_cmd(op, pick_value());
      if (op != OP_UNUSED) begin
        counted++;
        seg_left--;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_q.size() > 0 || in_tvalid) @(posedge clk);
    for (int i = 0; i < 50000 && expected_q.size() > 0; i++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (expected_q.size() > 0) begin
      errors++;
      $display("%0d expected results never arrived", expected_q.size());
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
